>>> design/smpg_pkg.sv
// Package for the stepper move pulse generator: microstep mode codes,
// configuration register indexes, the speed to period function and step constants.
// Depends on nothing; every design file refers to it by scoped names.
`default_nettype none
package smpg_pkg;

  localparam int STEP_COUNT_BITS_DEF = 16;
  localparam int PULSES_DONE_W       = 16;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 8;
  localparam int ANGLE_W             = 21;
  localparam int PERIOD_W            = 8;

  // floor(w / 45) for w < 2**22 + 1 as (w * RECIP_45) >> RECIP_45_SHIFT
  localparam int        RECIP_45_SHIFT = 28;
  localparam logic [22:0] RECIP_45     = 23'd5965233;
  localparam int        QUOT_W         = 17;

  // floor(x / 99) for x <= 12078 as (x * RECIP_99) >> RECIP_99_SHIFT
  localparam int        RECIP_99_SHIFT = 15;
  localparam logic [8:0] RECIP_99      = 9'd331;

  localparam logic [7:0] SPEED_RESET = 8'd50;
  localparam logic [7:0] SPEED_MIN   = 8'd1;
  localparam logic [7:0] SPEED_MAX   = 8'd100;
  localparam logic [7:0] PERIOD_BASE = 8'd222;
  localparam logic [6:0] PERIOD_SLOPE = 7'd122;

  typedef enum logic [1:0] {
    MODE_HALF      = 2'd0,
    MODE_QUARTER   = 2'd1,
    MODE_EIGHTH    = 2'd2,
    MODE_SIXTEENTH = 2'd3
  } mode_t;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_MODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPEED = 2'd1;

  typedef struct packed {
    mode_t                mode;
    logic [PERIOD_W-1:0]  period;
  } cfg_t;

  function automatic logic [PERIOD_W-1:0] period_of(input logic [7:0] speed);
    logic [7:0]  p;
    logic [13:0] x;
    logic [22:0] prod;
    logic [7:0]  q;
    p = speed;
    if (p > SPEED_MAX) p = SPEED_MAX;
    if (p < SPEED_MIN) p = SPEED_MIN;
    x = 14'(p - SPEED_MIN) * 14'(PERIOD_SLOPE);
    prod = 23'(x) * 23'(RECIP_99);
    q = 8'(prod >> RECIP_99_SHIFT);
    return PERIOD_W'(PERIOD_BASE - q);
  endfunction

endpackage
`default_nettype wire

>>> design/smpg_cfg.sv
// Configuration registers: microstep mode and the pulse period derived from speed.
// Depends on smpg_pkg for register indexes, mode codes and period_of.
`default_nettype none
module smpg_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  input  wire logic [smpg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [smpg_pkg::CFG_DATA_W-1:0]    cfg_data,
  output smpg_pkg::cfg_t                          cfg_out
);

  smpg_pkg::mode_t              mode_r, mode_nxt;
  logic [smpg_pkg::PERIOD_W-1:0] period_r, period_nxt;

  always_comb begin
    mode_nxt   = mode_r;
    period_nxt = period_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        smpg_pkg::CFG_IDX_MODE:  mode_nxt = smpg_pkg::mode_t'(cfg_data[1:0]);
        smpg_pkg::CFG_IDX_SPEED: period_nxt = smpg_pkg::period_of(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= smpg_pkg::MODE_SIXTEENTH;
      period_r <= smpg_pkg::period_of(smpg_pkg::SPEED_RESET);
    end else begin
      mode_r   <= mode_nxt;
      period_r <= period_nxt;
    end
  end

  assign cfg_out.mode   = mode_r;
  assign cfg_out.period = period_r;

endmodule
`default_nettype wire

>>> design/smpg_step_calc.sv
// Step count of a move: floor(|angle| * multiplier / 180), saturated to the counter.
// Depends on smpg_pkg for mode codes and the reciprocal constant.
`default_nettype none
module smpg_step_calc #(
  parameter int STEP_COUNT_BITS = smpg_pkg::STEP_COUNT_BITS_DEF
) (
  input  wire logic [smpg_pkg::ANGLE_W-1:0]  angle,
  input  smpg_pkg::mode_t                    mode,
  output logic                               neg,
  output logic [STEP_COUNT_BITS-1:0]         steps
);

  localparam int WIDE_W = 33;
  localparam logic [WIDE_W-1:0] STEP_MAX = (WIDE_W'(1) << STEP_COUNT_BITS) - WIDE_W'(1);

  logic [smpg_pkg::ANGLE_W-1:0]   mag;
  logic [22:0]                    w;
  logic [45:0]                    prod;
  logic [smpg_pkg::QUOT_W-1:0]    q;
  logic [smpg_pkg::QUOT_W-1:0]    quot;

  always_comb begin
    neg = angle[smpg_pkg::ANGLE_W-1];
    mag = neg ? (~angle + smpg_pkg::ANGLE_W'(1)) : angle;
    case (mode)
      smpg_pkg::MODE_EIGHTH:    w = 23'(mag) << 1;
      smpg_pkg::MODE_SIXTEENTH: w = 23'(mag) << 2;
      default:                  w = 23'(mag);
    endcase
    prod = 46'(w) * 46'(smpg_pkg::RECIP_45);
    q    = smpg_pkg::QUOT_W'(prod >> smpg_pkg::RECIP_45_SHIFT);
    quot = (mode == smpg_pkg::MODE_HALF) ? (q >> 1) : q;
    if (WIDE_W'(quot) > STEP_MAX) begin
      steps = STEP_COUNT_BITS'(STEP_MAX);
    end else begin
      steps = STEP_COUNT_BITS'(quot);
    end
  end

endmodule
`default_nettype wire

>>> design/stepper_move_pulse_generator_core.sv
// Top level of the stepper move pulse generator: input register, move and tick
// state update, result register. Uses smpg_pkg, smpg_cfg and smpg_step_calc.
//
//  channel | ports                                   | handshake
//  in      | in_opcode, in_angle                     | in_valid / in_stall
//  out     | out_step_pulse .. out_pulses_done       | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// One beat per cycle in unless stalled; each yields one registered result beat.
// The state update of one beat is a single pass from the input register.
// Reset (rst_n low, synchronous) clears state; mode 16x, speed 50 percent.
// A stalled result holds; the input register still takes one more beat.
// cfg_ready is always high.
`default_nettype none
module stepper_move_pulse_generator_core #(
  parameter int STEP_COUNT_BITS = smpg_pkg::STEP_COUNT_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_opcode,
  input  wire logic signed [smpg_pkg::ANGLE_W-1:0] in_angle,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_step_pulse,
  output logic                                     out_direction,
  output logic                                     out_mode_pin_one,
  output logic                                     out_mode_pin_two,
  output logic                                     out_ready_res,
  output logic [smpg_pkg::PULSES_DONE_W-1:0]       out_pulses_done,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [smpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [smpg_pkg::CFG_DATA_W-1:0]     cfg_data
);

  smpg_pkg::cfg_t cfg;

  logic                               s1_valid_r, s1_valid_nxt;
  logic                               s1_opcode_r;
  logic [smpg_pkg::ANGLE_W-1:0]       s1_angle_r;

  logic                               busy_r, busy_nxt;
  logic                               dir_r, dir_nxt;
  logic [STEP_COUNT_BITS-1:0]         target_r, target_nxt;
  logic [STEP_COUNT_BITS-1:0]         pulse_count_r, pulse_count_nxt;
  logic [smpg_pkg::PERIOD_W-1:0]      period_count_r, period_count_nxt;
  logic [smpg_pkg::PERIOD_W-1:0]      period_inc;

  logic                               out_valid_r, out_valid_nxt;
  logic                               out_pulse_r, out_pulse_nxt;
  logic                               out_dir_r;
  logic                               out_pin_one_r;
  logic                               out_pin_two_r;
  logic                               out_ready_r;
  logic [smpg_pkg::PULSES_DONE_W-1:0] out_done_r;

  logic                               can_out;
  logic                               adv;
  logic                               in_acc;
  logic                               move_neg;
  logic [STEP_COUNT_BITS-1:0]         move_steps;

  assign cfg_ready = 1'b1;

  smpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_out   (cfg)
  );

  smpg_step_calc #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_step_calc (
    .angle (s1_angle_r),
    .mode  (cfg.mode),
    .neg   (move_neg),
    .steps (move_steps)
  );

  assign can_out  = !out_valid_r || !out_stall;
  assign adv      = s1_valid_r && can_out;
  assign in_stall = s1_valid_r && !can_out;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_comb begin
    busy_nxt         = busy_r;
    dir_nxt          = dir_r;
    target_nxt       = target_r;
    pulse_count_nxt  = pulse_count_r;
    period_count_nxt = period_count_r;
    out_pulse_nxt    = 1'b0;
    period_inc       = period_count_r + smpg_pkg::PERIOD_W'(1);
    if (s1_opcode_r) begin
      if (!busy_r && (move_steps != '0)) begin
        busy_nxt         = 1'b1;
        dir_nxt          = move_neg;
        target_nxt       = move_steps;
        pulse_count_nxt  = '0;
        period_count_nxt = '0;
      end
    end else if (busy_r) begin
      if (period_count_r == '0) begin
        out_pulse_nxt   = 1'b1;
        pulse_count_nxt = pulse_count_r + STEP_COUNT_BITS'(1);
      end
      if (out_pulse_nxt && (pulse_count_nxt == target_r)) begin
        busy_nxt         = 1'b0;
        period_count_nxt = '0;
      end else if (period_inc >= cfg.period) begin
        period_count_nxt = '0;
      end else begin
        period_count_nxt = period_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      busy_r         <= 1'b0;
      dir_r          <= 1'b0;
      target_r       <= '0;
      pulse_count_r  <= '0;
      period_count_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        busy_r         <= busy_nxt;
        dir_r          <= dir_nxt;
        target_r       <= target_nxt;
        pulse_count_r  <= pulse_count_nxt;
        period_count_r <= period_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_opcode_r <= in_opcode;
      s1_angle_r  <= in_angle;
    end
    if (adv) begin
      out_pulse_r   <= out_pulse_nxt;
      out_dir_r     <= dir_nxt;
      out_pin_one_r <= (cfg.mode == smpg_pkg::MODE_HALF) ||
                       (cfg.mode == smpg_pkg::MODE_SIXTEENTH);
      out_pin_two_r <= (cfg.mode == smpg_pkg::MODE_QUARTER) ||
                       (cfg.mode == smpg_pkg::MODE_SIXTEENTH);
      out_ready_r   <= !busy_nxt;
      out_done_r    <= smpg_pkg::PULSES_DONE_W'(pulse_count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_pulse   = out_pulse_r;
  assign out_direction    = out_dir_r;
  assign out_mode_pin_one = out_pin_one_r;
  assign out_mode_pin_two = out_pin_two_r;
  assign out_ready_res    = out_ready_r;
  assign out_pulses_done  = out_done_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held beat");

  a_busy_below_target: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pulse_count_r < target_r))
    else $error("busy with pulse count at or past target");

  a_idle_period_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (period_count_r == '0))
    else $error("period counter running while idle");

endmodule
`default_nettype wire

>>> verif/smpg_checker.sv
// Checker for the stepper move pulse generator: watches the input, result and register
// write channels, predicts each result beat and compares it field by field.
// Depends on smpg_pkg; also holds smpg_tb_pkg, shared with the testbench top.
package smpg_tb_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_MOVE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic        step_pulse;
    logic        direction;
    logic        mode_pin_one;
    logic        mode_pin_two;
    logic        ready_res;
    logic [15:0] pulses_done;
  } pins_t;

endpackage

module smpg_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_opcode,
  input  logic signed [smpg_pkg::ANGLE_W-1:0] in_angle,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_step_pulse,
  input  logic                                out_direction,
  input  logic                                out_mode_pin_one,
  input  logic                                out_mode_pin_two,
  input  logic                                out_ready_res,
  input  logic [smpg_pkg::PULSES_DONE_W-1:0]  out_pulses_done,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [smpg_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [smpg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                  pending,
  output int                                  n_fail,
  output int                                  moves_taken,
  output int                                  moves_finished,
  output int                                  pulses_seen
);

  smpg_pkg::mode_t    step_mode;
  logic [7:0]         speed_req;
  logic               busy;
  logic               dir_level;
  logic [15:0]        target_steps;
  logic [15:0]        pulse_cnt;
  int                 tick_in_period;
  smpg_tb_pkg::pins_t pins_q[$];
  int                 fails;
  int                 n_taken;
  int                 n_finished;
  int                 n_pulses;

  assign n_fail         = fails;
  assign moves_taken    = n_taken;
  assign moves_finished = n_finished;
  assign pulses_seen    = n_pulses;

  function automatic int ticks_per_step(input logic [7:0] spd);
    int p;
    p = spd;
    if (p > 100) p = 100;
    if (p < 1) p = 1;
    return 222 - ((p - 1) * 122) / 99;
  endfunction

  task automatic advance_motor(input logic op, input logic signed [20:0] ang);
    smpg_tb_pkg::pins_t r;
    int                 a;
    longint unsigned    mag;
    longint unsigned    steps;
    logic               pulse;
    pulse = 1'b0;
    if (op == smpg_tb_pkg::OP_MOVE) begin
      a = ang;
      mag = (a < 0) ? -a : a;
      if (!busy && mag != 0) begin
        steps = (mag * (longint'(2) << int'(step_mode))) / 180;
        if (steps > 65535) steps = 65535;
        if (steps != 0) begin
          busy = 1'b1;
          dir_level = (a < 0);
          target_steps = steps[15:0];
          pulse_cnt = '0;
          tick_in_period = 0;
          n_taken++;
        end
      end
    end else if (busy) begin
      if (tick_in_period == 0) begin
        pulse = 1'b1;
        pulse_cnt = pulse_cnt + 16'd1;
        n_pulses++;
      end
      if (pulse && pulse_cnt == target_steps) begin
        busy = 1'b0;
        tick_in_period = 0;
        n_finished++;
      end else begin
        tick_in_period++;
        if (tick_in_period >= ticks_per_step(speed_req)) tick_in_period = 0;
      end
    end
    r.step_pulse   = pulse;
    r.direction    = dir_level;
    r.mode_pin_one = (step_mode == smpg_pkg::MODE_HALF || step_mode == smpg_pkg::MODE_SIXTEENTH);
    r.mode_pin_two = (step_mode == smpg_pkg::MODE_QUARTER ||
                      step_mode == smpg_pkg::MODE_SIXTEENTH);
    r.ready_res    = !busy;
    r.pulses_done  = pulse_cnt;
    pins_q.push_back(r);
  endtask

  task automatic compare_pins(input smpg_tb_pkg::pins_t want, input smpg_tb_pkg::pins_t got);
    if (want.step_pulse !== got.step_pulse) begin
      $error("step_pulse: expected %0d, got %0d", want.step_pulse, got.step_pulse);
      fails++;
    end
    if (want.direction !== got.direction) begin
      $error("direction: expected %0d, got %0d", want.direction, got.direction);
      fails++;
    end
    if (want.mode_pin_one !== got.mode_pin_one) begin
      $error("mode_pin_one: expected %0d, got %0d", want.mode_pin_one, got.mode_pin_one);
      fails++;
    end
    if (want.mode_pin_two !== got.mode_pin_two) begin
      $error("mode_pin_two: expected %0d, got %0d", want.mode_pin_two, got.mode_pin_two);
      fails++;
    end
    if (want.ready_res !== got.ready_res) begin
      $error("ready_res: expected %0d, got %0d", want.ready_res, got.ready_res);
      fails++;
    end
    if (want.pulses_done !== got.pulses_done) begin
      $error("pulses_done: expected %0d, got %0d", want.pulses_done, got.pulses_done);
      fails++;
    end
  endtask

  initial begin
    fails      = 0;
    n_taken    = 0;
    n_finished = 0;
    n_pulses   = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    smpg_tb_pkg::pins_t got;
    if (!rst_n) begin
      step_mode      = smpg_pkg::MODE_SIXTEENTH;
      speed_req      = smpg_pkg::SPEED_RESET;
      busy           = 1'b0;
      dir_level      = 1'b0;
      target_steps   = '0;
      pulse_cnt      = '0;
      tick_in_period = 0;
      pins_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_step_pulse, out_direction, out_mode_pin_one, out_mode_pin_two,
                out_ready_res, out_pulses_done};
        if (pins_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fails++;
        end else begin
          compare_pins(pins_q.pop_front(), got);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == smpg_pkg::CFG_IDX_MODE) step_mode = smpg_pkg::mode_t'(cfg_data[1:0]);
        else if (cfg_index == smpg_pkg::CFG_IDX_SPEED) speed_req = cfg_data;
      end
      if (in_valid && !in_stall) advance_motor(in_opcode, in_angle);
    end
    pending <= pins_q.size();
  end

endmodule

>>> verif/stepper_move_pulse_generator_core_tb.sv
// Testbench top for stepper_move_pulse_generator_core: clock, reset, register writes,
// directed and random move/tick beats with random idling on both channels, verdict.
// Depends on smpg_pkg, smpg_tb_pkg and smpg_checker.
module stepper_move_pulse_generator_core_tb;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic                                in_opcode;
  logic signed [smpg_pkg::ANGLE_W-1:0] in_angle;
  logic                                out_valid;
  logic                                out_stall;
  logic                                out_step_pulse;
  logic                                out_direction;
  logic                                out_mode_pin_one;
  logic                                out_mode_pin_two;
  logic                                out_ready_res;
  logic [smpg_pkg::PULSES_DONE_W-1:0]  out_pulses_done;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [smpg_pkg::CFG_INDEX_W-1:0]    cfg_index;
  logic [smpg_pkg::CFG_DATA_W-1:0]     cfg_data;

  int   pending;
  int   n_fail;
  int   moves_taken;
  int   moves_finished;
  int   pulses_seen;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   cur_mode = int'(smpg_pkg::MODE_SIXTEENTH);
  int   n_beats = 0;
  logic last_ready = 1'b1;

  smpg_pkg::mode_t phase_mode[6] = '{smpg_pkg::MODE_SIXTEENTH, smpg_pkg::MODE_HALF,
                                     smpg_pkg::MODE_QUARTER, smpg_pkg::MODE_EIGHTH,
                                     smpg_pkg::MODE_SIXTEENTH, smpg_pkg::MODE_HALF};
  logic [7:0] phase_speed[6] = '{8'd100, 8'd0, 8'd255, 8'd1, 8'd73, 8'd101};

  stepper_move_pulse_generator_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_pulse   (out_step_pulse),
    .out_direction    (out_direction),
    .out_mode_pin_one (out_mode_pin_one),
    .out_mode_pin_two (out_mode_pin_two),
    .out_ready_res    (out_ready_res),
    .out_pulses_done  (out_pulses_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  smpg_checker u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_angle         (in_angle),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_step_pulse   (out_step_pulse),
    .out_direction    (out_direction),
    .out_mode_pin_one (out_mode_pin_one),
    .out_mode_pin_two (out_mode_pin_two),
    .out_ready_res    (out_ready_res),
    .out_pulses_done  (out_pulses_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pending          (pending),
    .n_fail           (n_fail),
    .moves_taken      (moves_taken),
    .moves_finished   (moves_finished),
    .pulses_seen      (pulses_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < snk_idle_pct);
    if (out_valid && !out_stall) last_ready <= out_ready_res;
  end

  initial begin
    #3000000;
    $display("stepper_move_pulse_generator_core regression: fail");
    $finish;
  end

  task automatic send_beat(input smpg_tb_pkg::opcode_t op, input logic signed [20:0] ang);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_angle  <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_beats++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_motor(input smpg_pkg::mode_t mode, input logic [7:0] speed);
    write_reg(smpg_pkg::CFG_IDX_MODE, 8'(mode));
    write_reg(smpg_pkg::CFG_IDX_SPEED, speed);
    cur_mode = int'(mode);
  endtask

  function automatic logic signed [20:0] noise_angle();
    return 21'($urandom);
  endfunction

  // pick a magnitude that yields exactly k steps at the current microstep setting
  function automatic logic signed [20:0] angle_for_steps(input int k);
    int m;
    int lo;
    int hi;
    int mag;
    m   = 2 << cur_mode;
    lo  = (180 * k + m - 1) / m;
    hi  = (180 * (k + 1) + m - 1) / m - 1;
    mag = $urandom_range(hi, lo);
    return $urandom_range(1) ? 21'(-mag) : 21'(mag);
  endfunction

  task automatic send_random;
    int r;
    int k;
    r = $urandom_range(99);
    if (r < 70) begin
      send_beat(smpg_tb_pkg::OP_TICK, noise_angle());
    end else if (r < 88) begin
      k = $urandom_range(1) ? 1 : $urandom_range(3, 2);
      send_beat(smpg_tb_pkg::OP_MOVE, angle_for_steps(k));
    end else if (r < 94) begin
      send_beat(smpg_tb_pkg::OP_MOVE, angle_for_steps(0));
    end else begin
      // full-width angle lands while busy, so it is dropped
      send_beat(smpg_tb_pkg::OP_MOVE, angle_for_steps(1));
      send_beat(smpg_tb_pkg::OP_MOVE, noise_angle());
    end
  endtask

  initial begin
    int start;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = smpg_tb_pkg::OP_TICK;
    in_angle  = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = smpg_pkg::CFG_IDX_MODE;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 28;
    snk_idle_pct = 53;
    send_beat(smpg_tb_pkg::OP_TICK, 21'sd0);
    send_beat(smpg_tb_pkg::OP_TICK, -21'sd1);
    send_beat(smpg_tb_pkg::OP_MOVE, 21'sd0);
    send_beat(smpg_tb_pkg::OP_MOVE, 21'sd11);
    send_beat(smpg_tb_pkg::OP_MOVE, -21'sd11);
    send_beat(smpg_tb_pkg::OP_MOVE, -21'sd12);
    send_beat(smpg_tb_pkg::OP_MOVE, 21'sd1048575);
    send_beat(smpg_tb_pkg::OP_MOVE, -21'sd1048576);
    send_beat(smpg_tb_pkg::OP_TICK, 21'sd0);
    send_beat(smpg_tb_pkg::OP_TICK, 21'sd0);
    send_beat(smpg_tb_pkg::OP_MOVE, 21'sd23);
    send_beat(smpg_tb_pkg::OP_MOVE, -21'sd23);
    repeat (6) send_beat(smpg_tb_pkg::OP_TICK, noise_angle());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 53;
        snk_idle_pct = 28;
      end else if (ph == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      set_motor(phase_mode[ph], phase_speed[ph]);
      start = n_beats;
      while (n_beats - start < 190) send_random();
      drain();
    end

    // run out the current move, then load a saturating one
    while (!last_ready) begin
      repeat (40) send_beat(smpg_tb_pkg::OP_TICK, noise_angle());
      drain();
    end
    set_motor(smpg_pkg::MODE_SIXTEENTH, 8'd100);
    send_beat(smpg_tb_pkg::OP_MOVE, -21'sd1048576);
    send_beat(smpg_tb_pkg::OP_MOVE, 21'sd1048575);
    repeat (30) send_beat(smpg_tb_pkg::OP_TICK, noise_angle());
    drain();
    repeat (8) @(posedge clk);

    $display("%0d beats over all microstep modes and speeds 0..255: %0d moves started,",
             n_beats, moves_taken);
    $display("%0d moves completed, %0d step pulses", moves_finished, pulses_seen);
    if (n_fail == 0) begin
      $display("stepper_move_pulse_generator_core regression: pass");
    end else begin
      $display("stepper_move_pulse_generator_core regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/smpg_pkg.sv
design/smpg_cfg.sv
design/smpg_step_calc.sv
design/stepper_move_pulse_generator_core.sv
verif/smpg_checker.sv
verif/stepper_move_pulse_generator_core_tb.sv
